// ----- rtl/core/sptbl_pkg.sv -----
// shared types and constants of the sorted point table interpolator
package sptbl_pkg;

  localparam int KEY_W = 32;
  localparam int DAT_W = 32;
  localparam int NUM_W = 82;  // dividend width: 49-bit offset times 33-bit slope
  localparam int DEN_W = 34;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [1:0] CFG_X_SCALE = 2'd0;
  localparam logic [1:0] CFG_Y_SCALE = 2'd1;
  localparam logic [1:0] CFG_START_X = 2'd2;

  localparam logic signed [32:0] Q16_ONE = 33'sd65536;
  localparam logic [NUM_W-1:0] Q_LIMIT = NUM_W'(1) << 62;

  typedef struct packed {
    logic             go;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/core/sptbl_div.sv -----
// shared restoring divider, one quotient bit per cycle
module sptbl_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sptbl_pkg::div_req_t            req,
  output sptbl_pkg::div_stat_t           stat,
  output logic [sptbl_pkg::NUM_W-1:0]    quo
);

  localparam int NW = sptbl_pkg::NUM_W;
  localparam int DW = sptbl_pkg::DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [DW:0] rem_sh;
  logic [DW:0] rem_sub;
  logic        ge;

  assign rem_sh  = {rem_r, num_r[NW-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.go) begin
      num_r  <= req.num;
      den_r  <= req.den;
      rem_r  <= '0;
      cnt_r  <= CW'(NW);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      num_r <= {num_r[NW-2:0], ge};
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = num_r;

endmodule

// ----- rtl/core/sorted_point_table_interpolator.sv -----
// sorted point table with insert, append, clear and interpolating query
//
//  channel | dir | fields
//  in_     | in  | tuser: mode; tdata: key_x, point_y
//  out_    | out | tuser: status; tdata: result_value, points_held
//  cfg_    | in  | x_scale, y_scale, append_start_x
//
//  one item at a time; in_tready is high only while the sequencer is idle
//  the scan reads the table point by point, an insert shifts each later point up
//  by one, and a query adds 33 multiply steps and two 82-step divider passes;
//  the worst case is a query past the last point; clear resets the point count
//  reset empties the table; no clearing pass; a waiting result does not block
//  taking the next item, only the delivery of that next item's result
module sorted_point_table_interpolator #(
  parameter  int TABLE_DEPTH = 64,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
  localparam int OUT_W = ((32 + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,   // key_x, point_y
  input  logic [1:0]       in_tuser,   // mode
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // result_value, points_held
  output logic [1:0]       out_tuser,  // status
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int NW    = sptbl_pkg::NUM_W;
  localparam int DW    = sptbl_pkg::DEN_W;

  typedef enum logic [24:0] {
    S_IDLE  = 25'h0000001, S_XS   = 25'h0000002, S_ALR  = 25'h0000004,
    S_ALC   = 25'h0000008, S_SINIT = 25'h0000010, S_SRD = 25'h0000020,
    S_SCMP  = 25'h0000040, S_UPD  = 25'h0000080, S_SHRD = 25'h0000100,
    S_SHWR  = 25'h0000200, S_INS  = 25'h0000400, S_VRD  = 25'h0000800,
    S_VCAP  = 25'h0001000, S_PR1  = 25'h0002000, S_PC1  = 25'h0004000,
    S_PR2   = 25'h0008000, S_PC2  = 25'h0010000, S_MUL  = 25'h0020000,
    S_D1GO  = 25'h0040000, S_D1W  = 25'h0080000, S_SUM  = 25'h0100000,
    S_D2GO  = 25'h0200000, S_D2W  = 25'h0400000, S_SAT  = 25'h0800000,
    S_OUT   = 25'h1000000
  } state_t;

  logic [31:0] key_mem [TABLE_DEPTH];
  logic [31:0] val_mem [TABLE_DEPTH];
  logic [31:0] key_q, val_q;

  state_t state_r, state_nxt;
  logic [15:0] x_scale_r, y_scale_r;
  logic [31:0] start_x_r;
  logic [1:0]  mode_r, mode_nxt;
  logic [31:0] key_r, key_nxt, y_r, y_nxt;
  logic signed [48:0] xcmp_r, xcmp_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt, ptr_r, ptr_nxt, cnt_r, cnt_nxt;
  logic eq_r, eq_nxt;
  logic [IDX_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [31:0] x1_r, x1_nxt, y1_r, y1_nxt;
  logic [48:0] d_r, d_nxt;
  logic [32:0] mdy_r, mdy_nxt, dx_r, dx_nxt;
  logic neg_r, neg_nxt;
  logic [NW-1:0] acc_r, acc_nxt;
  logic [5:0] mcnt_r, mcnt_nxt;
  logic signed [63:0] v_r, v_nxt;
  logic [31:0] res_r, res_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;
  logic [1:0] out_tuser_r;

  logic wr_key_en, wr_val_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0] wr_key, wr_val;

  sptbl_pkg::div_req_t  div_req;
  sptbl_pkg::div_stat_t div_st;
  logic [NW-1:0] div_quo;

  sptbl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_st),
    .quo   (div_quo)
  );

  logic signed [48:0] prod_xs, key_ext;
  logic signed [32:0] nx_app, dy, dxs;
  logic signed [48:0] d_full;
  logic [63:0] q_lim, v_mag;
  logic [15:0] ys;

  assign prod_xs = $signed(key_r) * $signed({1'b0, x_scale_r});
  assign key_ext = {{17{key_q[31]}}, key_q};
  assign nx_app  = $signed({key_q[31], key_q}) + sptbl_pkg::Q16_ONE;
  assign dy      = $signed({val_q[31], val_q}) - $signed({y1_r[31], y1_r});
  assign dxs     = $signed({key_q[31], key_q}) - $signed({x1_r[31], x1_r});
  assign d_full  = xcmp_r - $signed({{17{x1_r[31]}}, x1_r});
  assign q_lim   = (div_quo >= sptbl_pkg::Q_LIMIT) ? sptbl_pkg::Q_LIMIT[63:0] : div_quo[63:0];
  assign v_mag   = v_r[63] ? 64'(-v_r) : 64'(v_r);
  assign ys      = (y_scale_r == 16'd0) ? 16'd1 : y_scale_r;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    key_nxt     = key_r;
    y_nxt       = y_r;
    xcmp_nxt    = xcmp_r;
    pos_nxt     = pos_r;
    ptr_nxt     = ptr_r;
    cnt_nxt     = cnt_r;
    eq_nxt      = eq_r;
    rd_addr_nxt = rd_addr_r;
    x1_nxt      = x1_r;
    y1_nxt      = y1_r;
    d_nxt       = d_r;
    mdy_nxt     = mdy_r;
    dx_nxt      = dx_r;
    neg_nxt     = neg_r;
    acc_nxt     = acc_r;
    mcnt_nxt    = mcnt_r;
    v_nxt       = v_r;
    res_nxt     = res_r;
    stat_nxt    = stat_r;
    wr_key_en   = 1'b0;
    wr_val_en   = 1'b0;
    wr_addr     = pos_r[IDX_W-1:0];
    wr_key      = xcmp_r[31:0];
    wr_val      = y_r;
    div_req.go  = 1'b0;
    div_req.num = acc_r;
    div_req.den = {1'b0, dx_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt = in_tuser;
          key_nxt  = in_tdata[31:0];
          y_nxt    = in_tdata[63:32];
          res_nxt  = '0;
          stat_nxt = sptbl_pkg::STAT_OK;
          case (in_tuser)
            sptbl_pkg::MODE_INSERT: begin
              xcmp_nxt  = {{17{in_tdata[31]}}, in_tdata[31:0]};
              state_nxt = S_SINIT;
            end
            sptbl_pkg::MODE_APPEND: begin
              if (cnt_r == '0) begin
                xcmp_nxt  = {{17{start_x_r[31]}}, start_x_r};
                state_nxt = S_SINIT;
              end else begin
                rd_addr_nxt = IDX_W'(cnt_r - CNT_W'(1));
                state_nxt   = S_ALR;
              end
            end
            sptbl_pkg::MODE_QUERY: begin
              if (cnt_r == '0) begin
                stat_nxt  = sptbl_pkg::STAT_EMPTY;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_XS;
              end
            end
            default: begin
              cnt_nxt   = '0;
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_XS: begin
        xcmp_nxt = prod_xs;
        if (cnt_r == CNT_W'(1)) begin
          rd_addr_nxt = '0;
          state_nxt   = S_VRD;
        end else begin
          state_nxt = S_SINIT;
        end
      end
      S_ALR: state_nxt = S_ALC;
      S_ALC: begin
        // next key saturates at the top of the range
        if (!nx_app[32] && nx_app[31]) xcmp_nxt = 49'sh0_7fff_ffff;
        else                           xcmp_nxt = {{17{nx_app[31]}}, nx_app[31:0]};
        state_nxt = S_SINIT;
      end
      S_SINIT: begin
        rd_addr_nxt = '0;
        pos_nxt     = '0;
        eq_nxt      = 1'b0;
        state_nxt   = (cnt_r == '0) ? S_UPD : S_SRD;
      end
      S_SRD: state_nxt = S_SCMP;
      S_SCMP: begin
        if (key_ext > xcmp_r) begin
          state_nxt = S_UPD;
        end else begin
          pos_nxt = pos_r + CNT_W'(1);
          eq_nxt  = (key_ext == xcmp_r);
          if (pos_r + CNT_W'(1) == cnt_r) begin
            state_nxt = S_UPD;
          end else begin
            rd_addr_nxt = rd_addr_r + IDX_W'(1);
            state_nxt   = S_SRD;
          end
        end
      end
      S_UPD: begin
        if (mode_r == sptbl_pkg::MODE_QUERY) begin
          if (pos_r == '0) begin
            rd_addr_nxt = '0;
            state_nxt   = S_VRD;
          end else begin
            // past the last point, extrapolate along the last pair
            rd_addr_nxt = (pos_r >= cnt_r) ? IDX_W'(cnt_r - CNT_W'(2))
                                           : IDX_W'(pos_r - CNT_W'(1));
            state_nxt   = S_PR1;
          end
        end else if (eq_r) begin
          wr_val_en = 1'b1;
          wr_addr   = IDX_W'(pos_r - CNT_W'(1));
          state_nxt = S_OUT;
        end else if (cnt_r == CNT_W'(TABLE_DEPTH)) begin
          stat_nxt  = sptbl_pkg::STAT_FULL;
          state_nxt = S_OUT;
        end else begin
          ptr_nxt = cnt_r;
          if (cnt_r == pos_r) begin
            state_nxt = S_INS;
          end else begin
            rd_addr_nxt = IDX_W'(cnt_r - CNT_W'(1));
            state_nxt   = S_SHRD;
          end
        end
      end
      S_SHRD: state_nxt = S_SHWR;
      S_SHWR: begin
        wr_key_en = 1'b1;
        wr_val_en = 1'b1;
        wr_addr   = ptr_r[IDX_W-1:0];
        wr_key    = key_q;
        wr_val    = val_q;
        ptr_nxt   = ptr_r - CNT_W'(1);
        if (ptr_r - CNT_W'(1) == pos_r) begin
          state_nxt = S_INS;
        end else begin
          rd_addr_nxt = IDX_W'(ptr_r - CNT_W'(2));
          state_nxt   = S_SHRD;
        end
      end
      S_INS: begin
        wr_key_en = 1'b1;
        wr_val_en = 1'b1;
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_OUT;
      end
      S_VRD: state_nxt = S_VCAP;
      S_VCAP: begin
        v_nxt     = {{32{val_q[31]}}, val_q};
        state_nxt = S_D2GO;
      end
      S_PR1: state_nxt = S_PC1;
      S_PC1: begin
        x1_nxt      = key_q;
        y1_nxt      = val_q;
        rd_addr_nxt = rd_addr_r + IDX_W'(1);
        state_nxt   = S_PR2;
      end
      S_PR2: state_nxt = S_PC2;
      S_PC2: begin
        d_nxt     = d_full;
        neg_nxt   = dy[32];
        mdy_nxt   = dy[32] ? 33'(-dy) : 33'(dy);
        dx_nxt    = 33'(dxs);
        acc_nxt   = '0;
        mcnt_nxt  = 6'd33;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        // msb-first shift and add
        acc_nxt  = {acc_r[NW-2:0], 1'b0} + (mdy_r[32] ? NW'(d_r) : NW'(0));
        mdy_nxt  = {mdy_r[31:0], 1'b0};
        mcnt_nxt = mcnt_r - 6'd1;
        if (mcnt_r == 6'd1) state_nxt = S_D1GO;
      end
      S_D1GO: begin
        div_req.go = 1'b1;
        state_nxt  = S_D1W;
      end
      S_D1W: if (div_st.done) state_nxt = S_SUM;
      S_SUM: begin
        v_nxt     = neg_r ? $signed({{32{y1_r[31]}}, y1_r}) - $signed(q_lim)
                          : $signed({{32{y1_r[31]}}, y1_r}) + $signed(q_lim);
        state_nxt = S_D2GO;
      end
      S_D2GO: begin
        div_req.go  = 1'b1;
        div_req.num = NW'(v_mag);
        div_req.den = DW'(ys);
        state_nxt   = S_D2W;
      end
      S_D2W: if (div_st.done) state_nxt = S_SAT;
      S_SAT: begin
        if (v_r[63]) begin
          res_nxt = (div_quo > NW'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-div_quo[31:0]);
        end else begin
          res_nxt = (div_quo > NW'(32'h7fff_ffff)) ? 32'h7fff_ffff : div_quo[31:0];
        end
        state_nxt = S_OUT;
      end
      S_OUT: if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_key_en) key_mem[wr_addr] <= wr_key;
    if (wr_val_en) val_mem[wr_addr] <= wr_val;
    key_q <= key_mem[rd_addr_r];
    val_q <= val_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
      x_scale_r    <= 16'd1;
      y_scale_r    <= 16'd1;
      start_x_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_OUT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          sptbl_pkg::CFG_X_SCALE: x_scale_r <= cfg_wdata[15:0];
          sptbl_pkg::CFG_Y_SCALE: y_scale_r <= cfg_wdata[15:0];
          sptbl_pkg::CFG_START_X: start_x_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    key_r     <= key_nxt;
    y_r       <= y_nxt;
    xcmp_r    <= xcmp_nxt;
    pos_r     <= pos_nxt;
    ptr_r     <= ptr_nxt;
    eq_r      <= eq_nxt;
    rd_addr_r <= rd_addr_nxt;
    x1_r      <= x1_nxt;
    y1_r      <= y1_nxt;
    d_r       <= d_nxt;
    mdy_r     <= mdy_nxt;
    dx_r      <= dx_nxt;
    neg_r     <= neg_nxt;
    acc_r     <= acc_nxt;
    mcnt_r    <= mcnt_nxt;
    v_r       <= v_nxt;
    res_r     <= res_nxt;
    stat_r    <= stat_nxt;
    if (state_r == S_OUT && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= OUT_W'({cnt_r, res_r});
      out_tuser_r <= stat_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("point count beyond table depth");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == S_D1W || state_r == S_D2W))
    else $error("divider finished outside a wait state");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("insert did not grow the table");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && stat_r == sptbl_pkg::STAT_FULL) |-> cnt_r == CNT_W'(TABLE_DEPTH))
    else $error("full status on a table with room");

endmodule
